// File: sv/bli_pkg.sv
// ---------------------------------------------------------------------------
// bli_pkg: shared types and codes of the bilinear LUT interpolator
// Payload structs of the request and response channels, opcodes and
// control register indexes.
// ---------------------------------------------------------------------------
package bli_pkg;

   localparam int COUNT_W = 5;

   localparam logic [1:0] OP_QUERY      = 2'd0;
   localparam logic [1:0] OP_WRITE_FLOW = 2'd1;
   localparam logic [1:0] OP_WRITE_TEMP = 2'd2;
   localparam logic [1:0] OP_WRITE_GRID = 2'd3;

   localparam logic REG_FLOW_COUNT = 1'b0;
   localparam logic REG_TEMP_COUNT = 1'b1;

   typedef struct packed {
      logic [1:0]         opcode;
      logic [7:0]         entry_index;
      logic signed [31:0] entry_value;
      logic signed [31:0] query_flow;
      logic signed [31:0] query_temp;
   } req_type;

   typedef struct packed {
      logic signed [31:0] pressure;
      logic               is_query;
   } rsp_type;

endpackage

// File: sv/bli_ram.sv
// ---------------------------------------------------------------------------
// bli_ram: generic RAM, one write port, two registered read ports
// ---------------------------------------------------------------------------
module bli_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem_ff[rd_addr_a];
      rd_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

// File: sv/bli_frac_div.sv
// ---------------------------------------------------------------------------
// bli_frac_div: pipelined fraction divider
// Restoring division, one quotient bit per stage, FRAC_BITS stages. The
// numerator must be below the denominator; the quotient is
// floor(num * 2^FRAC_BITS / den).
// ---------------------------------------------------------------------------
module bli_frac_div #(
   parameter int FRAC_BITS = 16
) (
   input  logic                 clock,
   input  logic [32:0]          num_in,
   input  logic [32:0]          den_in,
   output logic [FRAC_BITS-1:0] quot
);

   logic [32:0]          rem_ff  [FRAC_BITS];
   logic [32:0]          den_ff  [FRAC_BITS];
   logic [FRAC_BITS-1:0] quot_ff [FRAC_BITS];

   for (genvar k = 0; k < FRAC_BITS; k++) begin : g_stage
      logic [32:0]          prev_rem;
      logic [32:0]          prev_den;
      logic [FRAC_BITS-1:0] prev_quot;
      logic [33:0]          trial;
      logic                 take;
      logic [32:0]          rem_in;
      logic [FRAC_BITS-1:0] quot_in;

      if (k == 0) begin : g_first
         assign prev_rem  = num_in;
         assign prev_den  = den_in;
         assign prev_quot = '0;
      end else begin : g_next
         assign prev_rem  = rem_ff[k-1];
         assign prev_den  = den_ff[k-1];
         assign prev_quot = quot_ff[k-1];
      end

      always_comb begin
         trial   = {prev_rem, 1'b0};
         take    = (trial >= {1'b0, prev_den});
         rem_in  = take ? 33'(trial - {1'b0, prev_den}) : trial[32:0];
         quot_in = {prev_quot[FRAC_BITS-2:0], take};
      end

      always_ff @(posedge clock) begin
         rem_ff[k]  <= rem_in;
         den_ff[k]  <= prev_den;
         quot_ff[k] <= quot_in;
      end
   end

   assign quot = quot_ff[FRAC_BITS-1];

endmodule

// File: sv/bilinear_lut_interpolator_top.sv
// ---------------------------------------------------------------------------
// bilinear_lut_interpolator_top: 2-D non-uniform LUT with bilinear lookup
// Loads flow axis, temperature axis and table entries; answers queries with
// the bilinearly interpolated table value.
// ---------------------------------------------------------------------------
// Usage:
//   Request channel: an item transfers on a rising edge with start high and
//   busy low. Opcodes write a flow point, a temperature point or a table
//   entry, or query the table at (query_flow, query_temp).
//   Response channel: every item gives one result, rsp_strobe high for one
//   cycle; writes answer pressure 0 with is_query low. Results come in order.
//   Each result passes the bracket search, the store address and RAM read
//   stages, the one-bit-per-stage fraction divider, the lerp stages m1, m2
//   and m3 and the output register before the strobe.
//   Throughput: one query per cycle. A write waits (busy) while a query sits
//   in the first two stages, which read the axis and table stores.
//   Control registers: flow_count at 0x0, temp_count at 0x4; write them only
//   while no item is in flight.
//   Reset clears the counts and the pipeline; stores stay undefined until
//   written. The receiver cannot stall the result stream.
// ---------------------------------------------------------------------------
module bilinear_lut_interpolator_top #(
   parameter int MAX_FLOW_POINTS = 16,
   parameter int MAX_TEMP_POINTS = 16,
   parameter int FRAC_BITS       = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  bli_pkg::req_type req_payload,
   output logic             rsp_strobe,
   output bli_pkg::rsp_type rsp_payload,
   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic [2:0]       paddr,
   input  logic [31:0]      pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   localparam int FA_W       = $clog2(MAX_FLOW_POINTS);
   localparam int TA_W       = $clog2(MAX_TEMP_POINTS);
   localparam int NF_W       = $clog2(MAX_FLOW_POINTS + 1);
   localparam int NT_W       = $clog2(MAX_TEMP_POINTS + 1);
   localparam int GRID_DEPTH = MAX_FLOW_POINTS * MAX_TEMP_POINTS;
   localparam int GA_W       = $clog2(GRID_DEPTH);
   localparam int DIFF_W     = 33;
   localparam int PROD_W     = FRAC_BITS + 1 + DIFF_W;
   localparam logic signed [PROD_W-1:0] ROUND_BIAS = PROD_W'((1 << FRAC_BITS) - 1);

   // Divide by 2^FRAC_BITS, truncating toward zero.
   function automatic logic signed [DIFF_W-1:0] scale_down(
      input logic signed [PROD_W-1:0] p);
      logic signed [PROD_W-1:0] adj;
      begin
         adj = p + (p[PROD_W-1] ? ROUND_BIAS : '0);
         return DIFF_W'(adj >>> FRAC_BITS);
      end
   endfunction

   function automatic logic signed [DIFF_W-1:0] sub33(
      input logic signed [31:0] b, input logic signed [31:0] a);
      return DIFF_W'(b) - DIFF_W'(a);
   endfunction

   // ---------------- control registers ----------------
   logic [bli_pkg::COUNT_W-1:0] flow_count_ff;
   logic [bli_pkg::COUNT_W-1:0] temp_count_ff;
   logic                        csr_write;

   assign csr_write = psel & penable & pwrite;
   assign pready    = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         flow_count_ff <= '0;
         temp_count_ff <= '0;
      end else if (csr_write) begin
         unique case (paddr[2])
            bli_pkg::REG_FLOW_COUNT: flow_count_ff <= pwdata[bli_pkg::COUNT_W-1:0];
            bli_pkg::REG_TEMP_COUNT: temp_count_ff <= pwdata[bli_pkg::COUNT_W-1:0];
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         bli_pkg::REG_FLOW_COUNT: prdata = 32'(flow_count_ff);
         bli_pkg::REG_TEMP_COUNT: prdata = 32'(temp_count_ff);
      endcase
   end

   logic [NF_W-1:0] nf;
   logic [NT_W-1:0] nt;

   assign nf = (32'(flow_count_ff) > MAX_FLOW_POINTS) ? NF_W'(MAX_FLOW_POINTS)
                                                      : NF_W'(flow_count_ff);
   assign nt = (32'(temp_count_ff) > MAX_TEMP_POINTS) ? NT_W'(MAX_TEMP_POINTS)
                                                      : NT_W'(temp_count_ff);

   // ---------------- accept and store writes ----------------
   logic s0_vld_ff, s0_qry_ff;
   logic s1_vld_ff, s1_qry_ff;
   logic accept;
   logic flow_we, temp_we, grid_we;

   assign busy   = ((s0_vld_ff & s0_qry_ff) | (s1_vld_ff & s1_qry_ff))
                   & (req_payload.opcode != bli_pkg::OP_QUERY);
   assign accept = start & ~busy;

   assign flow_we = accept & (req_payload.opcode == bli_pkg::OP_WRITE_FLOW)
                    & (32'(req_payload.entry_index) < MAX_FLOW_POINTS);
   assign temp_we = accept & (req_payload.opcode == bli_pkg::OP_WRITE_TEMP)
                    & (32'(req_payload.entry_index) < MAX_TEMP_POINTS);
   assign grid_we = accept & (req_payload.opcode == bli_pkg::OP_WRITE_GRID)
                    & (32'(req_payload.entry_index) < GRID_DEPTH);

   logic signed [31:0] flow_pts_ff [MAX_FLOW_POINTS];
   logic signed [31:0] temp_pts_ff [MAX_TEMP_POINTS];

   always_ff @(posedge clock) begin
      if (flow_we) begin
         flow_pts_ff[FA_W'(req_payload.entry_index)] <= req_payload.entry_value;
      end
      if (temp_we) begin
         temp_pts_ff[TA_W'(req_payload.entry_index)] <= req_payload.entry_value;
      end
   end

   // ---------------- stage 0: bracket search ----------------
   logic signed [31:0] s0_flow_ff, s0_temp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_vld_ff <= 1'b0;
      end else begin
         s0_vld_ff <= accept;
      end
      s0_qry_ff  <= (req_payload.opcode == bli_pkg::OP_QUERY);
      s0_flow_ff <= req_payload.query_flow;
      s0_temp_ff <= req_payload.query_temp;
   end

   logic [MAX_FLOW_POINTS-1:0] f_gt;
   logic [FA_W-1:0]            f_last, f_hit, f_idx;
   logic                       f_int;
   logic [MAX_TEMP_POINTS-1:0] t_gt;
   logic [TA_W-1:0]            t_last, t_hit, t_idx;
   logic                       t_int;

   always_comb begin
      for (int i = 0; i < MAX_FLOW_POINTS; i++) begin
         f_gt[i] = flow_pts_ff[i] > s0_flow_ff;
      end
      f_last = FA_W'(nf - NF_W'(1));
      f_hit  = f_last;
      for (int i = MAX_FLOW_POINTS - 1; i >= 1; i--) begin
         if (FA_W'(i) < f_last && f_gt[i]) begin
            f_hit = FA_W'(i);
         end
      end
      f_int = 1'b0;
      if (!f_gt[0] && s0_flow_ff == flow_pts_ff[0] || f_gt[0]) begin
         f_idx = '0;
      end else if (!f_gt[f_last]) begin
         f_idx = f_last;
      end else begin
         f_idx = f_hit - FA_W'(1);
         f_int = 1'b1;
      end
   end

   always_comb begin
      for (int i = 0; i < MAX_TEMP_POINTS; i++) begin
         t_gt[i] = temp_pts_ff[i] > s0_temp_ff;
      end
      t_last = TA_W'(nt - NT_W'(1));
      t_hit  = t_last;
      for (int i = MAX_TEMP_POINTS - 1; i >= 1; i--) begin
         if (TA_W'(i) < t_last && t_gt[i]) begin
            t_hit = TA_W'(i);
         end
      end
      t_int = 1'b0;
      if (!t_gt[0] && s0_temp_ff == temp_pts_ff[0] || t_gt[0]) begin
         t_idx = '0;
      end else if (!t_gt[t_last]) begin
         t_idx = t_last;
      end else begin
         t_idx = t_hit - TA_W'(1);
         t_int = 1'b1;
      end
   end

   // ---------------- stage 1: store addresses ----------------
   logic               s1_zero_ff, s1_fint_ff, s1_tint_ff;
   logic [FA_W-1:0]    s1_qi_ff;
   logic [TA_W-1:0]    s1_ti_ff;
   logic signed [31:0] s1_flow_ff, s1_temp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= s0_vld_ff;
      end
      s1_qry_ff  <= s0_qry_ff;
      s1_zero_ff <= ~s0_qry_ff | (nf == '0) | (nt == '0);
      s1_fint_ff <= f_int;
      s1_tint_ff <= t_int;
      s1_qi_ff   <= f_idx;
      s1_ti_ff   <= t_idx;
      s1_flow_ff <= s0_flow_ff;
      s1_temp_ff <= s0_temp_ff;
   end

   logic [NF_W:0]   qi_next;
   logic [NT_W:0]   ti_next;
   logic [FA_W-1:0] qn;
   logic [TA_W-1:0] tn;
   logic [GA_W-1:0] g00_addr, g01_addr, g10_addr, g11_addr, row0, row1;

   always_comb begin
      qi_next  = (NF_W + 1)'(s1_qi_ff) + (NF_W + 1)'(1);
      ti_next  = (NT_W + 1)'(s1_ti_ff) + (NT_W + 1)'(1);
      qn       = (qi_next < (NF_W + 1)'(nf)) ? FA_W'(qi_next) : FA_W'(nf - NF_W'(1));
      tn       = (ti_next < (NT_W + 1)'(nt)) ? TA_W'(ti_next) : TA_W'(nt - NT_W'(1));
      row0     = GA_W'(GA_W'(s1_ti_ff) * GA_W'(nf));
      row1     = GA_W'(GA_W'(tn) * GA_W'(nf));
      g00_addr = row0 + GA_W'(s1_qi_ff);
      g01_addr = row0 + GA_W'(qn);
      g10_addr = row1 + GA_W'(s1_qi_ff);
      g11_addr = row1 + GA_W'(qn);
   end

   logic [31:0] f_lo, f_hi, t_lo, t_hi, g00, g01, g10, g11;

   bli_ram #(.WIDTH(32), .DEPTH(MAX_FLOW_POINTS)) u_flow_ram (
      .clock     (clock),
      .wr_en     (flow_we),
      .wr_addr   (FA_W'(req_payload.entry_index)),
      .wr_data   (req_payload.entry_value),
      .rd_addr_a (s1_qi_ff),
      .rd_addr_b (FA_W'(qi_next)),
      .rd_data_a (f_lo),
      .rd_data_b (f_hi)
   );

   bli_ram #(.WIDTH(32), .DEPTH(MAX_TEMP_POINTS)) u_temp_ram (
      .clock     (clock),
      .wr_en     (temp_we),
      .wr_addr   (TA_W'(req_payload.entry_index)),
      .wr_data   (req_payload.entry_value),
      .rd_addr_a (s1_ti_ff),
      .rd_addr_b (TA_W'(ti_next)),
      .rd_data_a (t_lo),
      .rd_data_b (t_hi)
   );

   bli_ram #(.WIDTH(32), .DEPTH(GRID_DEPTH)) u_grid_ram0 (
      .clock     (clock),
      .wr_en     (grid_we),
      .wr_addr   (GA_W'(req_payload.entry_index)),
      .wr_data   (req_payload.entry_value),
      .rd_addr_a (g00_addr),
      .rd_addr_b (g01_addr),
      .rd_data_a (g00),
      .rd_data_b (g01)
   );

   bli_ram #(.WIDTH(32), .DEPTH(GRID_DEPTH)) u_grid_ram1 (
      .clock     (clock),
      .wr_en     (grid_we),
      .wr_addr   (GA_W'(req_payload.entry_index)),
      .wr_data   (req_payload.entry_value),
      .rd_addr_a (g10_addr),
      .rd_addr_b (g11_addr),
      .rd_data_a (g10),
      .rd_data_b (g11)
   );

   // ---------------- stage 2: fraction operands ----------------
   logic               s2_vld_ff, s2_qry_ff, s2_zero_ff, s2_fint_ff, s2_tint_ff;
   logic signed [31:0] s2_flow_ff, s2_temp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else begin
         s2_vld_ff <= s1_vld_ff;
      end
      s2_qry_ff  <= s1_qry_ff;
      s2_zero_ff <= s1_zero_ff;
      s2_fint_ff <= s1_fint_ff;
      s2_tint_ff <= s1_tint_ff;
      s2_flow_ff <= s1_flow_ff;
      s2_temp_ff <= s1_temp_ff;
   end

   logic        f_ok, t_ok;
   logic [32:0] f_num, f_den, t_num, t_den;

   // Zero-span or clamped brackets divide 0 by 1.
   always_comb begin
      f_ok  = s2_fint_ff & ($signed(f_hi) > $signed(f_lo)) & (s2_flow_ff > $signed(f_lo));
      t_ok  = s2_tint_ff & ($signed(t_hi) > $signed(t_lo)) & (s2_temp_ff > $signed(t_lo));
      f_num = f_ok ? 33'(sub33(s2_flow_ff, $signed(f_lo))) : 33'd0;
      f_den = f_ok ? 33'(sub33($signed(f_hi), $signed(f_lo))) : 33'd1;
      t_num = t_ok ? 33'(sub33(s2_temp_ff, $signed(t_lo))) : 33'd0;
      t_den = t_ok ? 33'(sub33($signed(t_hi), $signed(t_lo))) : 33'd1;
   end

   logic [FRAC_BITS-1:0] f_frac, t_frac;

   bli_frac_div #(.FRAC_BITS(FRAC_BITS)) u_flow_div (
      .clock  (clock),
      .num_in (f_num),
      .den_in (f_den),
      .quot   (f_frac)
   );

   bli_frac_div #(.FRAC_BITS(FRAC_BITS)) u_temp_div (
      .clock  (clock),
      .num_in (t_num),
      .den_in (t_den),
      .quot   (t_frac)
   );

   // Side data travels alongside the divider stages.
   logic               d_vld_ff  [FRAC_BITS];
   logic               d_qry_ff  [FRAC_BITS];
   logic               d_zero_ff [FRAC_BITS];
   logic signed [31:0] d_g00_ff  [FRAC_BITS];
   logic signed [31:0] d_g01_ff  [FRAC_BITS];
   logic signed [31:0] d_g10_ff  [FRAC_BITS];
   logic signed [31:0] d_g11_ff  [FRAC_BITS];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < FRAC_BITS; k++) begin
            d_vld_ff[k] <= 1'b0;
         end
      end else begin
         d_vld_ff[0] <= s2_vld_ff;
         for (int k = 1; k < FRAC_BITS; k++) begin
            d_vld_ff[k] <= d_vld_ff[k-1];
         end
      end
      d_qry_ff[0]  <= s2_qry_ff;
      d_zero_ff[0] <= s2_zero_ff;
      d_g00_ff[0]  <= $signed(g00);
      d_g01_ff[0]  <= $signed(g01);
      d_g10_ff[0]  <= $signed(g10);
      d_g11_ff[0]  <= $signed(g11);
      for (int k = 1; k < FRAC_BITS; k++) begin
         d_qry_ff[k]  <= d_qry_ff[k-1];
         d_zero_ff[k] <= d_zero_ff[k-1];
         d_g00_ff[k]  <= d_g00_ff[k-1];
         d_g01_ff[k]  <= d_g01_ff[k-1];
         d_g10_ff[k]  <= d_g10_ff[k-1];
         d_g11_ff[k]  <= d_g11_ff[k-1];
      end
   end

   localparam int LAST = FRAC_BITS - 1;

   // ---------------- m1: flow products ----------------
   logic                     m1_vld_ff, m1_qry_ff, m1_zero_ff;
   logic signed [PROD_W-1:0] m1_p0_ff, m1_p1_ff;
   logic signed [31:0]       m1_a0_ff, m1_a1_ff;
   logic [FRAC_BITS-1:0]     m1_tf_ff;
   logic signed [PROD_W-1:0] fq_x;

   assign fq_x = PROD_W'($signed({1'b0, f_frac}));

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_vld_ff <= 1'b0;
      end else begin
         m1_vld_ff <= d_vld_ff[LAST];
      end
      m1_qry_ff  <= d_qry_ff[LAST];
      m1_zero_ff <= d_zero_ff[LAST];
      m1_a0_ff   <= d_g00_ff[LAST];
      m1_a1_ff   <= d_g10_ff[LAST];
      m1_tf_ff   <= t_frac;
      m1_p0_ff   <= fq_x * PROD_W'(sub33(d_g01_ff[LAST], d_g00_ff[LAST]));
      m1_p1_ff   <= fq_x * PROD_W'(sub33(d_g11_ff[LAST], d_g10_ff[LAST]));
   end

   // ---------------- m2: row values ----------------
   logic                 m2_vld_ff, m2_qry_ff, m2_zero_ff;
   logic signed [31:0]   m2_v0_ff, m2_v1_ff;
   logic [FRAC_BITS-1:0] m2_tf_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         m2_vld_ff <= 1'b0;
      end else begin
         m2_vld_ff <= m1_vld_ff;
      end
      m2_qry_ff  <= m1_qry_ff;
      m2_zero_ff <= m1_zero_ff;
      m2_tf_ff   <= m1_tf_ff;
      m2_v0_ff   <= 32'(DIFF_W'(m1_a0_ff) + scale_down(m1_p0_ff));
      m2_v1_ff   <= 32'(DIFF_W'(m1_a1_ff) + scale_down(m1_p1_ff));
   end

   // ---------------- m3: temperature product ----------------
   logic                     m3_vld_ff, m3_qry_ff, m3_zero_ff;
   logic signed [31:0]       m3_v0_ff;
   logic signed [PROD_W-1:0] m3_p_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         m3_vld_ff <= 1'b0;
      end else begin
         m3_vld_ff <= m2_vld_ff;
      end
      m3_qry_ff  <= m2_qry_ff;
      m3_zero_ff <= m2_zero_ff;
      m3_v0_ff   <= m2_v0_ff;
      m3_p_ff    <= PROD_W'($signed({1'b0, m2_tf_ff}))
                    * PROD_W'(sub33(m2_v1_ff, m2_v0_ff));
   end

   // ---------------- output register ----------------
   logic             out_vld_ff;
   bli_pkg::rsp_type out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= m3_vld_ff;
      end
      out_ff.is_query <= m3_qry_ff;
      out_ff.pressure <= m3_zero_ff ? 32'sd0
                         : 32'(DIFF_W'(m3_v0_ff) + scale_down(m3_p_ff));
   end

   assign rsp_strobe  = out_vld_ff;
   assign rsp_payload = out_ff;

endmodule

// File: tb/sv/bli_checker.sv
// ---------------------------------------------------------------------------
// bli_checker: response checker of the bilinear LUT interpolator
// Watches the request, response and register channels. It keeps its own copy
// of the axes, table and counts, predicts every response and compares it
// field by field with the oldest prediction still waiting.
// ---------------------------------------------------------------------------
module bli_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             busy,
   input  bli_pkg::req_type req_payload,
   input  logic             rsp_strobe,
   input  bli_pkg::rsp_type rsp_payload,
   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic             pready,
   input  logic [2:0]       paddr,
   input  logic [31:0]      pwdata,
   output int               fail_count,
   output int               pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NF_MAX = 16;
   localparam int NT_MAX = 16;
   localparam int FB     = 16;

   logic signed [31:0]          flow_pts [NF_MAX];
   logic signed [31:0]          temp_pts [NT_MAX];
   logic signed [31:0]          grid     [NF_MAX*NT_MAX];
   logic [bli_pkg::COUNT_W-1:0] flow_cnt;
   logic [bli_pkg::COUNT_W-1:0] temp_cnt;
   bli_pkg::rsp_type            pressure_q[$];

   // Clamp onto the axis, find the lower bracket and the Q0.16 fraction.
   function automatic void bracket(input logic signed [31:0] axis [16], input int n,
                                   input longint v, output int idx, output longint frac);
      int     i;
      longint lo, hi;
      frac = 0;
      if (v <= longint'(axis[0])) begin
         idx = 0;
         return;
      end
      if (v >= longint'(axis[n-1])) begin
         idx = n - 1;
         return;
      end
      i = 1;
      while (i < n - 1 && longint'(axis[i]) <= v) i++;
      idx = i - 1;
      lo  = axis[i-1];
      hi  = axis[i];
      if (hi > lo && v > lo) frac = ((v - lo) << FB) / (hi - lo);
   endfunction

   function automatic longint cell_value(input int k);
      if (k >= NF_MAX*NT_MAX) return 0;
      return longint'(grid[k]);
   endfunction

   function automatic longint blend(input longint a, input longint b, input longint f);
      longint p;
      p = f * (b - a);
      if (p < 0) return a - ((-p) >> FB);
      return a + (p >> FB);
   endfunction

   function automatic bli_pkg::rsp_type interpolate(input bli_pkg::req_type r);
      bli_pkg::rsp_type res;
      int               nf, nt, fi, ti, fn, tn;
      longint           ff, tf, v0, v1;
      nf = (flow_cnt > NF_MAX) ? NF_MAX : flow_cnt;
      nt = (temp_cnt > NT_MAX) ? NT_MAX : temp_cnt;
      res.pressure = '0;
      res.is_query = (r.opcode == bli_pkg::OP_QUERY);
      if (r.opcode == bli_pkg::OP_QUERY && nf != 0 && nt != 0) begin
         bracket(flow_pts, nf, longint'(r.query_flow), fi, ff);
         bracket(temp_pts, nt, longint'(r.query_temp), ti, tf);
         fn = (fi + 1 < nf) ? fi + 1 : nf - 1;
         tn = (ti + 1 < nt) ? ti + 1 : nt - 1;
         v0 = blend(cell_value(ti*nf + fi), cell_value(ti*nf + fn), ff);
         v1 = blend(cell_value(tn*nf + fi), cell_value(tn*nf + fn), ff);
         res.pressure = 32'(blend(v0, v1, tf));
      end
      return res;
   endfunction

   task automatic report(input string what, input longint want, input longint got);
      $display("MISMATCH %s: expected %0d, got %0d at %0t", what, want, got, $realtime);
      fail_count++;
   endtask

   always @(posedge clock) begin
      bli_pkg::rsp_type want;
      if (reset) begin
         flow_cnt   = '0;
         temp_cnt   = '0;
         pressure_q.delete();
         fail_count = 0;
         pending    <= 0;
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (paddr[2])
               bli_pkg::REG_FLOW_COUNT: flow_cnt = pwdata[bli_pkg::COUNT_W-1:0];
               bli_pkg::REG_TEMP_COUNT: temp_cnt = pwdata[bli_pkg::COUNT_W-1:0];
            endcase
         end
         if (rsp_strobe) begin
            if (pressure_q.size() == 0) begin
               report("unexpected response", 0, 1);
            end else begin
               want = pressure_q.pop_front();
               if (rsp_payload.pressure !== want.pressure)
                  report("pressure", want.pressure, rsp_payload.pressure);
               if (rsp_payload.is_query !== want.is_query)
                  report("is_query", want.is_query, rsp_payload.is_query);
            end
         end
         if (start && !busy) begin
            pressure_q.push_back(interpolate(req_payload));
            case (req_payload.opcode)
               bli_pkg::OP_WRITE_FLOW:
                  if (req_payload.entry_index < NF_MAX)
                     flow_pts[req_payload.entry_index] = req_payload.entry_value;
               bli_pkg::OP_WRITE_TEMP:
                  if (req_payload.entry_index < NT_MAX)
                     temp_pts[req_payload.entry_index] = req_payload.entry_value;
               bli_pkg::OP_WRITE_GRID:
                  grid[req_payload.entry_index] = req_payload.entry_value;
               default: ;
            endcase
         end
         pending <= pressure_q.size();
      end
   end

endmodule

// File: tb/sv/bilinear_lut_interpolator_top_test.sv
// ---------------------------------------------------------------------------
// bilinear_lut_interpolator_top_test: testbench of the bilinear LUT lookup
// Loads both axes and the whole table, then runs queries and rewrites under
// a series of count settings and sender gap rates; the checker predicts and
// compares every response.
// ---------------------------------------------------------------------------
module bilinear_lut_interpolator_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 300000;
   localparam int SETTLE      = 40;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic             busy;
   bli_pkg::req_type req_payload = '0;
   logic             rsp_strobe;
   bli_pkg::rsp_type rsp_payload;
   logic             psel = 1'b0;
   logic             penable = 1'b0;
   logic             pwrite = 1'b0;
   logic [2:0]       paddr = '0;
   logic [31:0]      pwdata = '0;
   logic [31:0]      prdata;
   logic             pready;
   int               fail_count;
   int               pending;
   int               cycles = 0;
   int               gap_pct = 0;

   logic signed [31:0] flow_axis [16];
   logic signed [31:0] temp_axis [16];

   bilinear_lut_interpolator_top u_dut (
      .clock, .reset, .start, .busy, .req_payload, .rsp_strobe, .rsp_payload,
      .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
   );

   bli_checker u_checker (
      .clock, .reset, .start, .busy, .req_payload, .rsp_strobe, .rsp_payload,
      .psel, .penable, .pwrite, .pready, .paddr, .pwdata, .fail_count, .pending
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // Hold start high across back-to-back transfers; drop it only for gaps.
   task automatic issue(input logic [1:0] op, input logic [7:0] idx,
                        input logic signed [31:0] val, input logic signed [31:0] qf,
                        input logic signed [31:0] qt);
      while ($urandom_range(99) < gap_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      req_payload <= '{opcode: op, entry_index: idx, entry_value: val,
                       query_flow: qf, query_temp: qt};
      start <= 1'b1;
      do @(posedge clock); while (busy);
      if (op == bli_pkg::OP_WRITE_FLOW && idx < 16) flow_axis[idx] = val;
      if (op == bli_pkg::OP_WRITE_TEMP && idx < 16) temp_axis[idx] = val;
   endtask

   task automatic drain();
      start <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic csr_write(input logic reg_idx, input logic [31:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {reg_idx, 2'b00};
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic signed [31:0] near_point(input logic signed [31:0] axis [16]);
      longint v;
      v = longint'(axis[$urandom_range(15)]) + $signed($urandom_range(32'h8_0000)) - 32'h4_0000;
      if ($urandom_range(9) == 0) return $urandom;
      return 32'(v);
   endfunction

   task automatic random_item();
      int sel;
      sel = $urandom_range(99);
      if (sel < 75)
         issue(bli_pkg::OP_QUERY, 8'($urandom), $urandom, near_point(flow_axis),
               near_point(temp_axis));
      else if (sel < 83)
         issue(bli_pkg::OP_WRITE_FLOW, 8'($urandom_range(19)), near_point(flow_axis),
               $urandom, $urandom);
      else if (sel < 91)
         issue(bli_pkg::OP_WRITE_TEMP, 8'($urandom_range(19)), near_point(temp_axis),
               $urandom, $urandom);
      else if (sel < 99)
         issue(bli_pkg::OP_WRITE_GRID, 8'($urandom), $urandom, $urandom, $urandom);
      else
         issue(2'($urandom), 8'hff, $urandom, $urandom, $urandom);
   endtask

   initial begin
      int          fc [7] = '{0, 16, 31, 16, 1, 2, 0};
      int          tc [7] = '{16, 0, 31, 16, 1, 3, 0};
      int          gaps [3] = '{0, 57, 28};
      logic signed [31:0] p;

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Empty axes answer zero without touching the stores.
      issue(bli_pkg::OP_QUERY, 8'hff, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
      issue(bli_pkg::OP_QUERY, 8'h00, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);

      // Load both axes ascending with uneven steps and one zero-span bracket.
      p = -32'sd600000;
      for (int i = 0; i < 16; i++) begin
         issue(bli_pkg::OP_WRITE_FLOW, 8'(i), p, $urandom, $urandom);
         p += (i == 5) ? 0 : $urandom_range(32'h6_0000, 32'h100);
      end
      p = -32'sd300000;
      for (int i = 0; i < 16; i++) begin
         issue(bli_pkg::OP_WRITE_TEMP, 8'(i), p, $urandom, $urandom);
         p += (i == 9) ? 0 : $urandom_range(32'h4_0000, 32'h80);
      end
      for (int k = 0; k < 256; k++)
         issue(bli_pkg::OP_WRITE_GRID, 8'(k), (k == 0) ? 32'h8000_0000
                                 : (k == 255) ? 32'h7fff_ffff
                                 : $urandom, $urandom, $urandom);
      // Out-of-range axis writes are ignored.
      issue(bli_pkg::OP_WRITE_FLOW, 8'd16, 32'h1234_5678, 32'sd0, 32'sd0);
      issue(bli_pkg::OP_WRITE_TEMP, 8'd255, 32'h8765_4321, 32'sd0, 32'sd0);
      drain();

      for (int ph = 0; ph < 7; ph++) begin
         csr_write(bli_pkg::REG_FLOW_COUNT, (ph == 6) ? $urandom_range(31) : 32'(fc[ph]));
         csr_write(bli_pkg::REG_TEMP_COUNT, (ph == 6) ? $urandom_range(31) : 32'(tc[ph]));
         if (ph == 3) begin
            gap_pct = 0;
            issue(bli_pkg::OP_QUERY, 8'd0, 32'sd0, 32'h8000_0000, 32'h8000_0000);
            issue(bli_pkg::OP_QUERY, 8'd0, 32'sd0, 32'h7fff_ffff, 32'h7fff_ffff);
            issue(bli_pkg::OP_QUERY, 8'd0, 32'sd0, flow_axis[0], temp_axis[15]);
            issue(bli_pkg::OP_QUERY, 8'd0, 32'sd0, flow_axis[6], temp_axis[10]);
            issue(bli_pkg::OP_QUERY, 8'd0, 32'sd0, flow_axis[5] + 1, temp_axis[9] + 1);
            issue(bli_pkg::OP_QUERY, 8'd0, 32'sd0, flow_axis[7] + 3, temp_axis[3] - 5);
            issue(bli_pkg::OP_QUERY, 8'd0, 32'sd0, flow_axis[14] + 1, temp_axis[14] + 1);
         end
         for (int g = 0; g < 3; g++) begin
            gap_pct = gaps[g];
            for (int n = 0; n < 5; n++) random_item();
            // Hold off until the pipeline is empty once mid-stream.
            if (ph == 4 && g == 1) drain();
         end
         drain();
      end

      if (fail_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

// File: bilinear_lut_interpolator_top.f
sv/bli_pkg.sv
sv/bli_ram.sv
sv/bli_frac_div.sv
sv/bilinear_lut_interpolator_top.sv
tb/sv/bli_checker.sv
tb/sv/bilinear_lut_interpolator_top_test.sv
